FILE: sv/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants for the mt19937 word generator: store geometry, twist
// and init constants, tempering masks.
// ----------------------------------------------------------------------------
package mtg_pkg;

  // index width covers 0..625
  localparam int IdxW = 10;

  localparam int unsigned StoreDepth = 624;

  localparam logic [IdxW-1:0] MtWords  = 10'd624;
  localparam logic [IdxW-1:0] MtShift  = 10'd397;
  localparam logic [IdxW-1:0] MtUninit = 10'd625;
  localparam logic [IdxW-1:0] MtLast   = 10'd623;

  localparam logic [31:0] TwistXor  = 32'h9908_b0df;
  localparam logic [31:0] HiBit     = 32'h8000_0000;
  localparam logic [31:0] LoBits    = 32'h7fff_ffff;
  localparam logic [31:0] InitMult  = 32'd1812433253;
  localparam logic [31:0] TemperB   = 32'h9d2c_5680;
  localparam logic [31:0] TemperC   = 32'hefc6_0000;
  localparam logic [31:0] SeedReset = 32'd5489;

endpackage

FILE: sv/mtg_ram.sv
// ----------------------------------------------------------------------------
// mtg_ram
// Generic simple dual-port ram: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int Width = 32,
  parameter int Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mtg_temper.sv
// ----------------------------------------------------------------------------
// mtg_temper
// Output tempering of one state word: two right shifts and two masked
// left shifts, each folded in by xor.
// ----------------------------------------------------------------------------
module mtg_temper
  import mtg_pkg::*;
(
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);

  logic [31:0] y1, y2, y3;

  // tempering chain
  assign y1     = word_i ^ (word_i >> 11);
  assign y2     = y1 ^ ((y1 << 7) & TemperB);
  assign y3     = y2 ^ ((y2 << 15) & TemperC);
  assign word_o = y3 ^ (y3 >> 18);

endmodule

FILE: sv/mersenne_twister_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// An accepted item with no refill due reads the store, then its tempered word
// enters the output register once that is free; no new item is taken before
// then. A twist of the store makes three ram accesses per word; a fill from
// seed writes the seed, then per word a multiply, then an add and write.
// Reset: the seed register takes 5489 and the index marks the store unfilled;
// the store itself is not cleared, the first item fills it from the seed.
// ----------------------------------------------------------------------------
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  // request items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] reseed_first, [7:1] zero fill
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] random_word
);

  typedef enum logic [3:0] {
    StIdle,
    StFillSeed,
    StFillMul,
    StFillWr,
    StTwRd0,
    StTwRdNxt,
    StTwRdFar,
    StTwWr,
    StRead,
    StOut
  } state_e;

  state_e state_q, state_d;

  logic [31:0]     seed_q, seed_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] cnt_q, cnt_d;     // fill position or twist position
  logic [31:0]     prev_q, prev_d;   // previous fill word
  logic [31:0]     prod_q, prod_d;
  logic [31:0]     cur_q, cur_d;     // store[k] during twist
  logic [31:0]     nxt_q, nxt_d;     // store[k+1] during twist
  logic            ovalid_q, ovalid_d;
  logic [31:0]     odata_q, odata_d;

  // ram control
  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  logic [31:0]     tempered;
  logic [31:0]     fill_word;
  logic [31:0]     twist_y, twist_word;
  logic [IdxW-1:0] nxt_addr, far_addr;
  logic [IdxW:0]   far_sum;

  mtg_ram #(
    .Width (32),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mtg_temper u_temper (
    .word_i (ram_rdata),
    .word_o (tempered)
  );

  // neighbour addresses for the twist, wrapped at the store depth
  assign nxt_addr = (cnt_q == MtLast) ? '0 : cnt_q + 1'b1;
  assign far_sum  = {1'b0, cnt_q} + {1'b0, MtShift};
  assign far_addr = (far_sum >= {1'b0, MtWords}) ? IdxW'(far_sum - {1'b0, MtWords})
                                                 : far_sum[IdxW-1:0];

  // init recurrence tail and twist word
  assign fill_word  = prod_q + {{(32-IdxW){1'b0}}, cnt_q};
  assign twist_y    = (cur_q & HiBit) | (nxt_q & LoBits);
  assign twist_word = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TwistXor : 32'h0);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  // sequencer and datapath
  always_comb begin
    state_d   = state_q;
    seed_d    = seed_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    prev_d    = prev_q;
    prod_d    = prod_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = fill_word;
    ram_raddr = idx_q;

    if (cfg_valid_i) begin
      seed_d = cfg_data_i;
    end
    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tdata_i[0] || idx_q > MtWords) begin
            state_d = StFillSeed;
          end else if (idx_q == MtWords) begin
            state_d = StTwRd0;
          end else begin
            state_d = StRead;
          end
        end
      end
      // store[0] takes the seed
      StFillSeed: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_q;
        prev_d    = seed_q;
        cnt_d     = IdxW'(1);
        state_d   = StFillMul;
      end
      StFillMul: begin
        prod_d  = InitMult * (prev_q ^ (prev_q >> 30));
        state_d = StFillWr;
      end
      StFillWr: begin
        ram_we = 1'b1;
        prev_d = fill_word;
        if (cnt_q == MtLast) begin
          idx_d   = MtWords;
          state_d = StTwRd0;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = StFillMul;
        end
      end
      // twist: prime with store[0]
      StTwRd0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        cnt_d     = '0;
        state_d   = StTwRdNxt;
      end
      StTwRdNxt: begin
        if (cnt_q == '0) begin
          cur_d = ram_rdata;
        end
        ram_re    = 1'b1;
        ram_raddr = nxt_addr;
        state_d   = StTwRdFar;
      end
      StTwRdFar: begin
        nxt_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = far_addr;
        state_d   = StTwWr;
      end
      StTwWr: begin
        ram_we    = 1'b1;
        ram_wdata = twist_word;
        cur_d     = nxt_q;
        if (cnt_q == MtLast) begin
          idx_d   = '0;
          state_d = StRead;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = StTwRdNxt;
        end
      end
      StRead: begin
        ram_re  = 1'b1;
        state_d = StOut;
      end
      // wait for a free output register
      StOut: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = tempered;
          idx_d    = idx_q + 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      seed_q   <= SeedReset;
      idx_q    <= MtUninit;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seed_q   <= seed_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    prev_q   <= prev_d;
    prod_q   <= prod_d;
    cur_q    <= cur_d;
    nxt_q    <= nxt_d;
    odata_q  <= odata_d;
  end

endmodule

FILE: test/mtg_stream_check.sv
// ----------------------------------------------------------------------------
// mtg_stream_check
// Monitors the seed, request and result channels of the word generator. It
// keeps its own copy of the mt19937 state, works out the tempered word for
// every accepted request and compares each accepted result with the oldest
// outstanding word.
// ----------------------------------------------------------------------------
module mtg_stream_check
  import mtg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed register write channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  // request items
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [7:0]  req_data_i,    // [0] reseed_first, [7:1] zero fill
  // result items
  input  logic        word_valid_i,
  input  logic        word_ready_i,
  input  logic [31:0] word_data_i,   // [31:0] random_word
  output int          pending_o,
  output int          errors_o
);

  logic [31:0] seed_reg;
  logic [31:0] mt_store [StoreDepth];
  int unsigned mt_pos;
  logic [31:0] words_due [$];

  // output tempering
  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // knuth multiplier fill from the seed register
  function automatic void fill_store();
    logic [31:0] p;
    mt_store[0] = seed_reg;
    for (int i = 1; i < StoreDepth; i++) begin
      p = mt_store[i-1];
      mt_store[i] = InitMult * (p ^ (p >> 30)) + 32'(i);
    end
    mt_pos = StoreDepth;
  endfunction

  // regenerate all 624 words in place
  function automatic void twist_store();
    int nxt;
    int far;
    logic [31:0] y;
    logic [31:0] v;
    for (int k = 0; k < StoreDepth; k++) begin
      nxt = (k + 1) % StoreDepth;
      far = (k + int'(MtShift)) % StoreDepth;
      y = (mt_store[k] & HiBit) | (mt_store[nxt] & LoBits);
      v = mt_store[far] ^ (y >> 1);
      if (y[0]) v = v ^ TwistXor;
      mt_store[k] = v;
    end
    mt_pos = 0;
  endfunction

  // one request: refill or twist as due, then draw
  function automatic logic [31:0] draw_word(input logic reseed);
    logic [31:0] w;
    if (reseed || mt_pos > StoreDepth) fill_store();
    if (mt_pos >= StoreDepth) twist_store();
    w = temper_word(mt_store[mt_pos]);
    mt_pos++;
    return w;
  endfunction

  // track the channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      seed_reg = SeedReset;
      mt_pos   = 32'(MtUninit);
      words_due.delete();
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) seed_reg = cfg_data_i;
      if (req_valid_i && req_ready_i) words_due.push_back(draw_word(req_data_i[0]));
      if (word_valid_i && word_ready_i) begin
        if (words_due.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected item, expected none, actual %h", $time, word_data_i);
        end else begin
          want = words_due.pop_front();
          if (word_data_i !== want) begin
            errors_o++;
            $display("%0t: random_word mismatch, expected %h, actual %h",
                     $time, want, word_data_i);
          end
        end
      end
    end
    pending_o = words_due.size();
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the mt19937 word generator: directed requests around reset,
// reseeds and seed extremes, then random phases of draws and reseeds with
// varying back-pressure. Checking is left to mtg_stream_check.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;    // [0] reseed_first, [7:1] zero fill
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;         // [31:0] random_word

  int words_pending;
  int error_count;
  int send_idle_pct = 8;
  int recv_idle_pct = 59;

  mersenne_twister_generator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  mtg_stream_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid_i),
    .req_ready_i  (s_axis_tready_o),
    .req_data_i   (s_axis_tdata_i),
    .word_valid_i (m_axis_tvalid_o),
    .word_ready_i (m_axis_tready_i),
    .word_data_i  (m_axis_tdata_o),
    .pending_o    (words_pending),
    .errors_o     (error_count)
  );

  // clock, period 12
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one request item, with random gaps before it
  task automatic send_request(input logic reseed);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, reseed};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // wait for every outstanding word, then let the block settle
  task automatic drain_words();
    s_axis_tvalid_i <= 1'b0;
    while (words_pending != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // seed write, only once the block is idle
  task automatic write_seed(input logic [31:0] value);
    drain_words();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // random phase: mostly draws, reseeds at the given odds
  task automatic random_phase(input int count, input int reseed_odds, input logic lead_reseed);
    for (int n = 0; n < count; n++)
      send_request((n == 0 && lead_reseed) || $urandom_range(reseed_odds - 1) == 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first request after reset uses the reset seed
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    // new seed has no effect until a reseed
    write_seed(32'h0000_0000);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);

    write_seed(32'hffff_ffff);
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // back-to-back reseeds
    write_seed(32'h0000_0001);
    repeat (2) send_request(1'b1);
    write_seed(32'h8000_0000);
    send_request(1'b1);
    send_request(1'b0);

    // sender idles lightly, receiver heavily
    write_seed($urandom());
    random_phase(100, 12, 1'b1);

    // the other way round
    send_idle_pct = 59;
    recv_idle_pct = 8;
    write_seed($urandom());
    random_phase(100, 12, 1'b1);

    // no idling; long run across a natural twist
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_seed($urandom());
    random_phase(640, 400, 1'b1);

    drain_words();
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // overall time limit
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: filelist.f
sv/mtg_pkg.sv
sv/mtg_ram.sv
sv/mtg_temper.sv
sv/mersenne_twister_generator.sv
test/mtg_stream_check.sv
test/tb_top.sv
